FILE: src/pattern_occurrence_line_counter_top_defines.svh
// Assertion macros used by the pattern occurrence line counter RTL.
`ifndef PATTERN_OCCURRENCE_LINE_COUNTER_TOP_DEFINES_SVH
`define PATTERN_OCCURRENCE_LINE_COUNTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during reset
`define POCL_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pocl assertion failed");
// next-cycle implication
`define POCL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pocl assertion failed");
`else
`define POCL_ASSERT_IMPLY(lbl, ante, cons)
`define POCL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/pocl_pkg.sv
// Types and constants of the pattern occurrence line counter.
package pocl_pkg;

	localparam int unsigned PATTERN_MAX_DEF = 16;
	localparam int unsigned PATTERN_CAP     = 16;	// bytes held by the two pattern registers
	localparam int unsigned LEN_W           = 5;
	localparam int unsigned LINE_W          = 24;
	localparam int unsigned LCOUNT_W        = 16;
	localparam int unsigned TOTAL_W         = 32;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned CFG_DATA_W      = 64;
	localparam int unsigned RQ_DEPTH        = 4;

	localparam logic [7:0]          NEWLINE     = 8'd10;
	localparam logic [LINE_W-1:0]   LINE_SAT    = '1;
	localparam logic [LCOUNT_W-1:0] LCOUNT_SAT  = '1;
	localparam logic [TOTAL_W-1:0]  TOTAL_SAT   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_PATTERN_LOW    = 2'd1,
		REG_PATTERN_HIGH   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_LINE    = 1'b0,
		KIND_SUMMARY = 1'b1
	} result_kind_t;

	typedef struct packed {
		logic advance;	// a text byte moves through the row
		logic flush;	// drop all partial matches
	} cell_ctrl_t;

	typedef struct packed {
		result_kind_t          kind;
		logic [LINE_W-1:0]     line_number;
		logic [LCOUNT_W-1:0]   line_matches;
		logic [TOTAL_W-1:0]    total_matches;
		logic                  none_found;
		logic                  last_of_run;
	} result_t;

endpackage

FILE: src/pattern_occurrence_line_counter_top.sv
// Pattern occurrence line counter: text in, per-line match reports and summaries out.
//
// Text channel: in_valid/in_stall carry text_byte and end_of_text. One byte is taken
// per cycle while in_stall is low; the shift-and row of cells updates in that same cycle.
// A newline closes the line; if it held a match, a line report is queued.
// end_of_text closes an open line (report if it matched), then queues a summary
// with the total and none_found, and starts a new text from line 1.
// Result channel: out_valid/out_stall. A result is written into the queue when the byte
// that caused it is taken. Results sit in a four-entry queue; in_stall rises while more than
// two results are queued, so with the receiver stalled the text keeps flowing until
// three or four results wait. Sustained rate is one byte per cycle, bounded by the
// one-per-cycle drain of the result queue when reports pile up.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while idle. Any write to a listed register drops partial matches.
// Reset: pattern empty, line number 1, counts zero, queue empty.
`include "pattern_occurrence_line_counter_top_defines.svh"

module pattern_occurrence_line_counter_top #(
	parameter int unsigned PATTERN_MAX = pocl_pkg::PATTERN_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pocl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pocl_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         text_byte,
	input  logic                               end_of_text,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               result_kind,
	output logic [pocl_pkg::LINE_W-1:0]        line_number,
	output logic [pocl_pkg::LCOUNT_W-1:0]      line_matches,
	output logic [pocl_pkg::TOTAL_W-1:0]       total_matches,
	output logic                               none_found,
	output logic                               last_of_run
);
	import pocl_pkg::*;

	logic [LEN_W-1:0]      pat_len_q;
	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [LINE_W-1:0]     line_q;
	logic [LCOUNT_W-1:0]   lcount_q;
	logic [TOTAL_W-1:0]    total_q;
	logic                  open_q;

	logic                  cfg_wr;
	logic                  cfg_hit;
	logic                  in_accept;
	logic                  is_newline;
	logic                  hit;
	logic [LCOUNT_W-1:0]   lc_upd;
	logic [TOTAL_W-1:0]    tot_upd;
	logic                  has_report;
	logic                  room_for_two;
	logic                  pop;
	result_t               rep;
	result_t               summ;
	result_t               din0;
	result_t               dout;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_comb begin
		unique case (cfg_reg_t'(cfg_index))
			REG_PATTERN_LENGTH,
			REG_PATTERN_LOW,
			REG_PATTERN_HIGH: cfg_hit = cfg_wr;
			default:          cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= '0;
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LENGTH: pat_len_q <= cfg_data[LEN_W-1:0];
				REG_PATTERN_LOW:    pat_lo_q  <= cfg_data;
				REG_PATTERN_HIGH:   pat_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall   = !room_for_two;
	assign in_accept  = in_valid & !in_stall;
	assign is_newline = text_byte == NEWLINE;

	pocl_chain #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_chain (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (in_accept & !end_of_text),
		.clear          (cfg_hit | (in_accept & (end_of_text | is_newline))),
		.text_byte      (text_byte),
		.pattern_length (pat_len_q),
		.pattern_bytes  ({pat_hi_q, pat_lo_q}),
		.hit            (hit)
	);

	// hit is never set on end of text, so these equal the held counts there
	assign lc_upd  = (hit && lcount_q != LCOUNT_SAT) ? lcount_q + 1'b1 : lcount_q;
	assign tot_upd = (hit && total_q != TOTAL_SAT) ? total_q + 1'b1 : total_q;

	assign has_report = (end_of_text ? open_q : is_newline) && (lc_upd != '0);

	always_comb begin
		rep.kind          = KIND_LINE;
		rep.line_number   = line_q;
		rep.line_matches  = lc_upd;
		rep.total_matches = tot_upd;
		rep.none_found    = 1'b0;
		rep.last_of_run   = !end_of_text;

		summ.kind          = KIND_SUMMARY;
		summ.line_number   = '0;
		summ.line_matches  = '0;
		summ.total_matches = total_q;
		summ.none_found    = total_q == '0;
		summ.last_of_run   = 1'b1;

		din0 = has_report ? rep : summ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= LINE_W'(1);
			lcount_q <= '0;
			total_q  <= '0;
			open_q   <= 1'b0;
		end else if (in_accept) begin
			if (end_of_text) begin
				line_q   <= LINE_W'(1);
				lcount_q <= '0;
				total_q  <= '0;
				open_q   <= 1'b0;
			end else begin
				total_q <= tot_upd;
				if (is_newline) begin
					if (line_q != LINE_SAT) begin
						line_q <= line_q + 1'b1;
					end
					lcount_q <= '0;
					open_q   <= 1'b0;
				end else begin
					lcount_q <= lc_upd;
					open_q   <= 1'b1;
				end
			end
		end
	end

	assign pop = out_valid & !out_stall;

	pocl_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push0        (in_accept & (has_report | end_of_text)),
		.push1        (in_accept & end_of_text & has_report),
		.din0         (din0),
		.din1         (summ),
		.pop          (pop),
		.dout         (dout),
		.not_empty    (out_valid),
		.room_for_two (room_for_two)
	);

	assign result_kind   = dout.kind;
	assign line_number   = dout.line_number;
	assign line_matches  = dout.line_matches;
	assign total_matches = dout.total_matches;
	assign none_found    = dout.none_found;
	assign last_of_run   = dout.last_of_run;

	`POCL_ASSERT_NEXT(a_eot_restarts, in_accept && end_of_text, line_q == LINE_W'(1) && total_q == '0 && !open_q)
	`POCL_ASSERT_NEXT(a_newline_closes, in_accept && !end_of_text && is_newline, !open_q && lcount_q == '0)
	`POCL_ASSERT_IMPLY(a_summary_fields, out_valid && result_kind, line_number == '0 && line_matches == '0 && last_of_run)
	`POCL_ASSERT_IMPLY(a_report_fields, out_valid && !result_kind, line_matches != '0 && !none_found && line_number != '0)

endmodule

FILE: src/pocl_cell.sv
// One shift-and cell: compares the text byte with its pattern byte and holds one progress bit.
module pocl_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  pocl_pkg::cell_ctrl_t ctrl,
	input  logic              prev_bit,
	input  logic              active,
	input  logic [7:0]        text_byte,
	input  logic [7:0]        pat_byte,
	output logic              nxt_bit,
	output logic              prog_q
);
	import pocl_pkg::*;

	assign nxt_bit = prev_bit & active & (text_byte == pat_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= 1'b0;
		end else if (ctrl.flush) begin
			prog_q <= 1'b0;
		end else if (ctrl.advance) begin
			prog_q <= nxt_bit;
		end
	end

endmodule

FILE: src/pocl_chain.sv
// Row of shift-and cells with match detection at the configured pattern length.
module pocl_chain #(
	parameter int unsigned PATTERN_MAX = pocl_pkg::PATTERN_MAX_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  logic                                  clear,
	input  logic [7:0]                            text_byte,
	input  logic [pocl_pkg::LEN_W-1:0]            pattern_length,
	input  logic [8*pocl_pkg::PATTERN_CAP-1:0]    pattern_bytes,
	output logic                                  hit
);
	import pocl_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PATTERN_MAX);

	logic [LEN_W-1:0]       eff_len;
	logic [PATTERN_MAX-1:0] active;
	logic [PATTERN_MAX-1:0] is_last;
	logic [PATTERN_MAX-1:0] nxt;
	logic [PATTERN_MAX-1:0] prog;
	logic [PATTERN_MAX-1:0] prev;
	cell_ctrl_t             ctrl;

	assign eff_len = (pattern_length > MAX_LEN) ? MAX_LEN : pattern_length;

	// a full match restarts the search after it
	assign hit          = advance & |(nxt & is_last);
	assign ctrl.advance = advance;
	assign ctrl.flush   = clear | hit;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		assign active[i]  = LEN_W'(i) < eff_len;
		assign is_last[i] = LEN_W'(i + 1) == eff_len;
		if (i == 0) begin : g_head
			assign prev[i] = 1'b1;
		end else begin : g_body
			assign prev[i] = prog[i-1];
		end

		pocl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.prev_bit  (prev[i]),
			.active    (active[i]),
			.text_byte (text_byte),
			.pat_byte  (pattern_bytes[8*i +: 8]),
			.nxt_bit   (nxt[i]),
			.prog_q    (prog[i])
		);
	end

endmodule

FILE: src/pocl_result_fifo.sv
// Small result queue: up to two pushes and one pop per cycle.
module pocl_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  logic              push1,
	input  pocl_pkg::result_t din0,
	input  pocl_pkg::result_t din1,
	input  logic              pop,
	output pocl_pkg::result_t dout,
	output logic              not_empty,
	output logic              room_for_two
);
	import pocl_pkg::*;

	localparam int unsigned PTR_W = $clog2(RQ_DEPTH);
	localparam int unsigned LVL_W = $clog2(RQ_DEPTH + 1);
	localparam logic [LVL_W-1:0] ROOM_LIMIT = LVL_W'(RQ_DEPTH - 2);

	result_t          mem_q [RQ_DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic [PTR_W-1:0] wr_ptr_nx1;
	logic [LVL_W-1:0] push_n;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(RQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_nx1   = ptr_inc(wr_ptr_q);
	assign push_n       = LVL_W'(push0) + LVL_W'(push1);
	assign dout         = mem_q[rd_ptr_q];
	assign not_empty    = level_q != '0;
	assign room_for_two = level_q <= ROOM_LIMIT;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push1) begin
			mem_q[wr_ptr_nx1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_nx1);
			end else if (push0) begin
				wr_ptr_q <= wr_ptr_nx1;
			end
			level_q <= level_q + push_n - LVL_W'(pop);
		end
	end

endmodule

FILE: verif/pocl_count_checker.sv
// Checker for the pattern occurrence line counter: predicts line reports and summaries, compares.
module pocl_count_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [pocl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pocl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [7:0]                      text_byte,
	input  logic                            end_of_text,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            result_kind,
	input  logic [pocl_pkg::LINE_W-1:0]     line_number,
	input  logic [pocl_pkg::LCOUNT_W-1:0]   line_matches,
	input  logic [pocl_pkg::TOTAL_W-1:0]    total_matches,
	input  logic                            none_found,
	input  logic                            last_of_run,
	output int                              fail_count,
	output int                              results_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import pocl_pkg::*;

	// predictor copy of the registers and of the block state
	logic [LEN_W-1:0]       pat_len = '0;
	logic [CFG_DATA_W-1:0]  pat_low = '0;
	logic [CFG_DATA_W-1:0]  pat_high = '0;
	logic [PATTERN_CAP-1:0] progress = '0;
	logic [LINE_W-1:0]      cur_line = 1;
	logic [LCOUNT_W-1:0]    line_hits = '0;
	logic [TOTAL_W-1:0]     text_hits = '0;
	logic                   line_open = 1'b0;

	result_t awaited_reports[$];
	result_t head;

	task automatic report_mismatch(input string msg);
		if (fail_count < 30)
			$display("mismatch at %0t ns: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic logic [7:0] pattern_at(input int unsigned i);
		return (i < 8) ? pat_low[8*i +: 8] : pat_high[8*(i-8) +: 8];
	endfunction

	task automatic clear_text();
		progress = '0;
		cur_line = 1;
		line_hits = '0;
		text_hits = '0;
		line_open = 1'b0;
	endtask

	task automatic scan_byte(input logic [7:0] c);
		int unsigned len;
		logic [PATTERN_CAP-1:0] hits;
		len = (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pat_len;
		hits = '0;
		if (len == 0) begin
			progress = '0;
			return;
		end
		for (int unsigned i = 0; i < len; i++)
			if (pattern_at(i) == c)
				hits[i] = 1'b1;
		progress = ((progress << 1) | 1) & hits;
		// full match: count it and restart the search after it
		if (progress[len-1]) begin
			if (line_hits != LCOUNT_SAT)
				line_hits++;
			if (text_hits != TOTAL_SAT)
				text_hits++;
			progress = '0;
		end
	endtask

	task automatic close_line(input logic last);
		result_t r;
		if (line_hits != 0) begin
			r.kind          = KIND_LINE;
			r.line_number   = cur_line;
			r.line_matches  = line_hits;
			r.total_matches = text_hits;
			r.none_found    = 1'b0;
			r.last_of_run   = last;
			awaited_reports.push_back(r);
		end
		if (cur_line != LINE_SAT)
			cur_line++;
		line_hits = '0;
		progress = '0;
		line_open = 1'b0;
	endtask

	task automatic count_item(input logic [7:0] c, input logic eot);
		result_t r;
		if (!eot) begin
			line_open = 1'b1;
			scan_byte(c);
			if (c == NEWLINE)
				close_line(1'b1);
		end else begin
			if (line_open)
				close_line(1'b0);
			r.kind          = KIND_SUMMARY;
			r.line_number   = '0;
			r.line_matches  = '0;
			r.total_matches = text_hits;
			r.none_found    = (text_hits == 0);
			r.last_of_run   = 1'b1;
			awaited_reports.push_back(r);
			clear_text();
		end
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_PATTERN_LENGTH: begin
				pat_len = d[LEN_W-1:0];
				progress = '0;
			end
			REG_PATTERN_LOW: begin
				pat_low = d;
				progress = '0;
			end
			REG_PATTERN_HIGH: begin
				pat_high = d;
				progress = '0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len = '0;
			pat_low = '0;
			pat_high = '0;
			clear_text();
			awaited_reports.delete();
			results_outstanding <= 0;
		end else begin
			// a result is never caused by the input transaction of the same edge
			if (out_valid && !out_stall) begin
				if (awaited_reports.size() == 0) begin
					report_mismatch("result transaction with nothing awaited");
				end else begin
					head = awaited_reports.pop_front();
					if (result_kind !== head.kind)
						report_mismatch($sformatf("result_kind got %0d want %0d",
							result_kind, head.kind));
					if (line_number !== head.line_number)
						report_mismatch($sformatf("line_number got %0d want %0d",
							line_number, head.line_number));
					if (line_matches !== head.line_matches)
						report_mismatch($sformatf("line_matches got %0d want %0d",
							line_matches, head.line_matches));
					if (total_matches !== head.total_matches)
						report_mismatch($sformatf("total_matches got %0d want %0d",
							total_matches, head.total_matches));
					if (none_found !== head.none_found)
						report_mismatch($sformatf("none_found got %0d want %0d",
							none_found, head.none_found));
					if (last_of_run !== head.last_of_run)
						report_mismatch($sformatf("last_of_run got %0d want %0d",
							last_of_run, head.last_of_run));
				end
			end
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				count_item(text_byte, end_of_text);
			results_outstanding <= awaited_reports.size();
		end
	end

endmodule

FILE: verif/tb_pattern_occurrence_line_counter_top.sv
// Testbench top for the pattern occurrence line counter: stimulus, idling, watchdog, verdict.
module tb_pattern_occurrence_line_counter_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pocl_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLDOFF_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            text_byte = '0;
	logic                  end_of_text = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  result_kind;
	logic [LINE_W-1:0]     line_number;
	logic [LCOUNT_W-1:0]   line_matches;
	logic [TOTAL_W-1:0]    total_matches;
	logic                  none_found;
	logic                  last_of_run;

	int mismatch_count;
	int results_outstanding;

	// stimulus knobs and the pattern currently loaded
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          holdoff_req = 0;
	int          holdoff_seen = 0;
	int          hold_left = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	logic [7:0]  pat [PATTERN_CAP];
	int unsigned pat_used = 0;

	pattern_occurrence_line_counter_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.text_byte     (text_byte),
		.end_of_text   (end_of_text),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.line_number   (line_number),
		.line_matches  (line_matches),
		.total_matches (total_matches),
		.none_found    (none_found),
		.last_of_run   (last_of_run)
	);

	pocl_count_checker count_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.text_byte           (text_byte),
		.end_of_text         (end_of_text),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.result_kind         (result_kind),
		.line_number         (line_number),
		.line_matches        (line_matches),
		.total_matches       (total_matches),
		.none_found          (none_found),
		.last_of_run         (last_of_run),
		.fail_count          (mismatch_count),
		.results_outstanding (results_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holdoff_req != holdoff_seen) begin
			holdoff_seen <= holdoff_req;
			hold_left <= HOLDOFF_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= c;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_pattern(input logic [LEN_W-1:0] len);
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pat[i];
			hi[8*i +: 8] = pat[8+i];
		end
		drain_results();
		repeat (8) @(posedge clk);
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
		pat_used = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len;
	endtask

	// small alphabet so that partial and overlapping matches are frequent
	task automatic fill_alphabet();
		for (int i = 0; i < PATTERN_CAP; i++)
			pat[i] = 8'h61 + 8'($urandom_range(2));
	endtask

	task automatic send_pattern_run();
		int unsigned cut;
		cut = pat_used;
		if ($urandom_range(4) == 0)
			cut = $urandom_range(pat_used - 1);
		for (int unsigned i = 0; i < cut; i++)
			send_item(pat[i], 1'b0);
		if (cut < pat_used)
			send_item(8'($urandom_range(255)), 1'b0);
	endtask

	task automatic random_text(input int n);
		int target;
		int r;
		target = items_sent + n;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 35 && pat_used > 0)
				send_pattern_run();
			else if (r < 50)
				send_item(NEWLINE, 1'b0);
			else if (r < 53)
				send_item(8'($urandom_range(255)), 1'b1);
			else if (r < 78 && pat_used > 0)
				send_item(pat[$urandom_range(pat_used - 1)], 1'b0);
			else
				send_item(8'($urandom_range(255)), 1'b0);
			if ($urandom_range(199) == 0)
				drain_results();
		end
	endtask

	initial begin
		for (int i = 0; i < PATTERN_CAP; i++)
			pat[i] = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pattern after reset, byte ignored with end of text
		send_item(8'h00, 1'b0);
		send_item(NEWLINE, 1'b0);
		send_item(8'hFF, 1'b1);

		// "aba": non-overlapping count, open line closed at end, back-to-back end of text
		pat[0] = 8'h61;
		pat[1] = 8'h62;
		pat[2] = 8'h61;
		apply_pattern(5'd3);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(NEWLINE, 1'b0);
		send_item(8'h78, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(8'h5A, 1'b1);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'hA5, 1'b1);

		// zero byte then newline as the pattern: match on the byte that closes the line
		pat[0] = 8'h00;
		pat[1] = NEWLINE;
		apply_pattern(5'd2);
		send_item(8'h00, 1'b0);
		send_item(NEWLINE, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(NEWLINE, 1'b0);
		send_item(8'h00, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 83;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 83;
				end
				default: begin
					send_idle_pct = 19;
					recv_stall_pct <= 19;
				end
			endcase
			case (ph)
				0: begin
					fill_alphabet();
					pat[0] = 8'h61;
					apply_pattern(5'd1);
					// long receiver hold-off while every line reports: fills the block
					holdoff_req <= holdoff_req + 1;
					repeat (20) begin
						send_item(8'h61, 1'b0);
						send_item(NEWLINE, 1'b0);
					end
					drain_results();
				end
				1: begin
					for (int i = 0; i < PATTERN_CAP; i++)
						pat[i] = 8'($urandom_range(255));
					apply_pattern(5'd16);
				end
				2: begin
					fill_alphabet();
					apply_pattern(5'd31);
				end
				3: begin
					for (int i = 0; i < PATTERN_CAP; i++)
						pat[i] = 8'($urandom_range(255));
					apply_pattern(5'd0);
				end
				4: begin
					int unsigned l;
					l = $urandom_range(6, 2);
					fill_alphabet();
					pat[l-1] = NEWLINE;
					apply_pattern(LEN_W'(l));
				end
				5: begin
					for (int i = 0; i < PATTERN_CAP; i++)
						pat[i] = 8'hFF;
					apply_pattern(5'd17);
				end
				6: begin
					fill_alphabet();
					apply_pattern(LEN_W'($urandom_range(31)));
				end
				default: begin
					fill_alphabet();
					apply_pattern(5'd3);
					write_reg(REG_UNMAPPED, {$urandom, $urandom});
				end
			endcase
			random_text(210);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/pocl_pkg.sv
src/pocl_cell.sv
src/pocl_chain.sv
src/pocl_result_fifo.sv
src/pattern_occurrence_line_counter_top.sv
verif/pocl_count_checker.sv
verif/tb_pattern_occurrence_line_counter_top.sv
